FILE: src/pmed_pkg.sv
`default_nettype none
package pmed_pkg;

  localparam int DEF_PALETTE_ENTRIES = 256;
  localparam int DEF_MAX_WIDTH       = 2048;

  // search lanes, one palette bank each
  localparam int LANES  = 16;
  localparam int LANE_W = 4;
  localparam int DIST_W = 18;   // 3 * 255^2 fits

  localparam int ERR_W  = 20;   // one channel error, scaled by 1024
  localparam int TAG_W  = 20;   // row epoch kept with each error slot
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_PIXEL = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_DITHER = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_COUNT  = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic        dither;
    logic [11:0] width;
    logic [8:0]  count;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] count;
  } srch_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] index;
    logic [23:0] rgb;
  } srch_rsp_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  index;
    logic [23:0] rgb;
  } pal_wr_t;

  typedef struct packed {
    logic [7:0] palette_index;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       end_of_row;
  } res_t;

endpackage
`default_nettype wire

FILE: src/pmed_pix_if.sv
`default_nettype none
interface pmed_pix_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source(output valid, func, entry_index, red, green, blue, input ready);
  modport sink(input valid, func, entry_index, red, green, blue, output ready);
endinterface
`default_nettype wire

FILE: src/pmed_res_if.sv
`default_nettype none
interface pmed_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_index;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       end_of_row;

  modport source(output valid, palette_index, red_out, green_out, blue_out, end_of_row,
                 input ready);
  modport sink(input valid, palette_index, red_out, green_out, blue_out, end_of_row,
               output ready);
endinterface
`default_nettype wire

FILE: src/pmed_cfg_if.sv
`default_nettype none
interface pmed_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/palette_map_error_diffusion.sv
`default_nettype none
// Palette mapper with optional Floyd-Steinberg dithering over serpentine rows.
// Load the palette (func 1), send begin-frame (func 0), then pixels (func 2) in visit
// order; each pixel returns one beat with the nearest entry, its color and an
// end-of-row flag. The search reads sixteen palette banks per cycle and feeds a
// two-stage distance and min-tree pipeline. Dithering adds one error read before the
// search and four read-modify-write passes on the error RAM (one read port, one write
// port) after it. Pixels run one at a time since each needs the error left by the
// one before. A two-deep queue in front keeps taking beats while a pixel is in work,
// and a result register lets the next pixel start while the last beat waits. After
// reset the error RAM, 2*2^ceil(log2(MAX_WIDTH+2)) entries (8192 at the default
// width), is swept clear with the input held off; config writes still land.
module palette_map_error_diffusion import pmed_pkg::*; #(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
  parameter int MAX_WIDTH       = DEF_MAX_WIDTH
) (
  input  logic clk,
  input  logic rst,
  pmed_pix_if.sink   pix,
  pmed_res_if.source res,
  pmed_cfg_if.sink   cfg
);

  cfg_t      cfg_r;
  logic      q_valid, q_pop, hold;
  item_t     q_item;
  srch_req_t srch_req;
  srch_rsp_t srch_rsp;
  pal_wr_t   pal_wr;
  logic      res_valid;
  res_t      res_data;

  // config registers, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.dither <= 1'b0;
      cfg_r.width  <= 12'd640;
      cfg_r.count  <= 9'd256;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_DITHER: cfg_r.dither <= cfg.data[0];
        REG_WIDTH:  cfg_r.width  <= cfg.data;
        REG_COUNT:  cfg_r.count  <= cfg.data[8:0];
        default: ;
      endcase
    end
  end

  // front: accept, drop unused codes, queue
  pmed_front u_front (
    .clk     (clk),
    .rst     (rst),
    .hold    (hold),
    .pix     (pix),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // back: position, error RAM, result register
  pmed_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .MAX_WIDTH       (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .hold      (hold),
    .srch_req  (srch_req),
    .srch_rsp  (srch_rsp),
    .pal_wr    (pal_wr),
    .res_valid (res_valid),
    .res       (res_data),
    .res_ready (res.ready)
  );

  // sixteen-lane nearest-entry search over the banked palette
  pmed_search #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_search (
    .clk (clk),
    .rst (rst),
    .req (srch_req),
    .wr  (pal_wr),
    .rsp (srch_rsp)
  );

  assign res.valid         = res_valid;
  assign res.palette_index = res_data.palette_index;
  assign res.red_out       = res_data.red_out;
  assign res.green_out     = res_data.green_out;
  assign res.blue_out      = res_data.blue_out;
  assign res.end_of_row    = res_data.end_of_row;

`ifndef SYNTHESIS
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    srch_rsp.done |=> !srch_rsp.done)
    else $error("search done held for more than one cycle");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    srch_req.start |-> !srch_rsp.busy)
    else $error("search started while busy");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (9'(res.palette_index) < 9'(PALETTE_ENTRIES)))
    else $error("palette index out of range");
`endif

endmodule
`default_nettype wire

FILE: src/pmed_front.sv
`default_nettype none
module pmed_front import pmed_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  hold,
  pmed_pix_if.sink pix,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t             fifo [QDEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  item_t             in_item;

  assign pix.ready = !hold && (count != CNT_W'(QDEPTH));

  always_comb begin
    in_item.func        = func_t'(pix.func);
    in_item.entry_index = pix.entry_index;
    in_item.red         = pix.red;
    in_item.green       = pix.green;
    in_item.blue        = pix.blue;
  end

  // func 3 is dropped here and never reaches the back end
  assign push    = pix.valid && pix.ready && (in_item.func != FUNC_NOP);
  assign q_valid = (count != '0);
  assign q_item  = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      if (q_pop) rptr <= (rptr == PTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !q_pop) count <= count + 1'b1;
      else if (!push && q_pop) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: src/pmed_search.sv
`default_nettype none
module pmed_search import pmed_pkg::*; #(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  input  srch_req_t req,
  input  pal_wr_t   wr,
  output srch_rsp_t rsp
);

  localparam int GROUPS = (PALETTE_ENTRIES + LANES - 1) / LANES;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int IDX_W  = GRP_W + LANE_W;

  logic [23:0]       mem [LANES][GROUPS];
  logic [23:0]       rdata [LANES];

  logic              run, v1, v2, last1, last2, done;
  logic [GRP_W-1:0]  grp, last_grp, g1, g2;
  logic [8:0]        count_r;

  logic [DIST_W-1:0] d1 [LANES];
  logic [LANES-1:0]  en1;
  logic [DIST_W-1:0] d2 [LANES];
  logic [LANES-1:0]  en2;
  logic [23:0]       rgb2 [LANES];

  // heap-ordered min tree, leaves at LANES..2*LANES-1, root at 1
  logic [DIST_W-1:0] nd_d [2*LANES];
  logic              nd_e [2*LANES];
  logic [LANE_W-1:0] nd_i [2*LANES];
  logic [23:0]       nd_rgb [2*LANES];

  logic [DIST_W-1:0] best_d;
  logic [IDX_W-1:0]  best_i;
  logic [23:0]       best_rgb;

  logic              busy, take;
  logic [GRP_W-1:0]  wr_grp;
  logic              wr_ok;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] m;
    m = (a >= b) ? a - b : b - a;
    return m * m;
  endfunction

  assign busy   = run || v1 || v2;
  assign take   = req.start && !busy;
  assign wr_grp = GRP_W'(wr.index >> LANE_W);
  assign wr_ok  = wr.en && ({1'b0, wr.index} < 9'(PALETTE_ENTRIES));

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (wr_ok && (wr.index[LANE_W-1:0] == LANE_W'(l))) mem[l][wr_grp] <= wr.rgb;
      rdata[l] <= mem[l][grp];
    end
  end

  // stage 1: one distance per lane
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      en1[l] = (9'({g1, LANE_W'(l)}) < count_r);
      d1[l]  = 18'(sq_diff(req.red,   rdata[l][23:16]))
             + 18'(sq_diff(req.green, rdata[l][15:8]))
             + 18'(sq_diff(req.blue,  rdata[l][7:0]));
    end
  end

  // stage 2: lower lane wins a tie
  always_comb begin
    nd_d[0]   = '0;
    nd_e[0]   = 1'b0;
    nd_i[0]   = '0;
    nd_rgb[0] = '0;
    for (int l = 0; l < LANES; l++) begin
      nd_d[LANES+l]   = d2[l];
      nd_e[LANES+l]   = en2[l];
      nd_i[LANES+l]   = LANE_W'(l);
      nd_rgb[LANES+l] = rgb2[l];
    end
    for (int n = LANES - 1; n >= 1; n--) begin
      if (nd_e[2*n+1] && (!nd_e[2*n] || (nd_d[2*n+1] < nd_d[2*n]))) begin
        nd_d[n]   = nd_d[2*n+1];
        nd_e[n]   = 1'b1;
        nd_i[n]   = nd_i[2*n+1];
        nd_rgb[n] = nd_rgb[2*n+1];
      end else begin
        nd_d[n]   = nd_d[2*n];
        nd_e[n]   = nd_e[2*n];
        nd_i[n]   = nd_i[2*n];
        nd_rgb[n] = nd_rgb[2*n];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= v2 && last2;
      v1   <= run;
      v2   <= v1;
      if (take) run <= 1'b1;
      else if (run && (grp == last_grp)) run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    last1 <= run && (grp == last_grp);
    last2 <= last1;
    g1    <= grp;
    g2    <= g1;
    if (take) begin
      grp      <= '0;
      last_grp <= GRP_W'((req.count - 9'd1) >> LANE_W);
      count_r  <= req.count;
    end else if (run && (grp != last_grp)) begin
      grp <= grp + 1'b1;
    end
    for (int l = 0; l < LANES; l++) begin
      d2[l]   <= d1[l];
      rgb2[l] <= rdata[l];
    end
    en2 <= en1;
    if (take) begin
      best_d <= '1;
    end else if (v2 && nd_e[1] && (nd_d[1] < best_d)) begin
      best_d   <= nd_d[1];
      best_i   <= {g2, nd_i[1]};
      best_rgb <= nd_rgb[1];
    end
  end

  always_comb begin
    rsp.busy  = busy;
    rsp.done  = done;
    rsp.index = 8'(best_i);
    rsp.rgb   = best_rgb;
  end

endmodule
`default_nettype wire

FILE: src/pmed_back.sv
`default_nettype none
module pmed_back import pmed_pkg::*; #(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
  parameter int MAX_WIDTH       = DEF_MAX_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  item_t     q_item,
  output logic      q_pop,
  output logic      hold,
  output srch_req_t srch_req,
  input  srch_rsp_t srch_rsp,
  output pal_wr_t   pal_wr,
  output logic      res_valid,
  output res_t      res,
  input  logic      res_ready
);

  localparam int SLOT_W  = $clog2(MAX_WIDTH + 2);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WID_W   = COL_W + 1;
  localparam int EADDR_W = SLOT_W + 1;
  localparam int EDEPTH  = 2 ** EADDR_W;
  localparam int ENTRY_W = TAG_W + 3 * ERR_W;
  localparam int Q_W     = ERR_W - 10;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_ADJ, S_WAIT, S_ERR, S_RMW_RD, S_RMW_WR, S_OUT
  } state_t;

  state_t              state;
  logic [EADDR_W-1:0]  clr_addr;
  logic [TAG_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic                rtl;
  logic [1:0]          k;
  logic [7:0]          adj [3];
  logic [7:0]          chosen [3];
  logic [7:0]          chosen_idx;
  logic [3*ERR_W-1:0]  addend [4];
  logic                start;
  logic                obuf_v;
  res_t                obuf;

  logic [ENTRY_W-1:0]  emem [EDEPTH];
  logic [ENTRY_W-1:0]  e_rdata;
  logic [EADDR_W-1:0]  e_raddr, rmw_addr, e_waddr;
  logic [ENTRY_W-1:0]  e_wdata;
  logic                e_we;

  logic [WID_W-1:0]    w_eff;
  logic [COL_W-1:0]    w_last, col_s;
  logic [SLOT_W-1:0]   s0, s1, s2, rmw_slot;
  logic [8:0]          n_eff;
  logic                row_end, out_free;
  logic [TAG_W-1:0]    rmw_tag;
  logic                rmw_bank, rd_ok;
  logic [7:0]          px [3];
  logic [7:0]          adj_next [3];

  function automatic logic signed [ERR_W-1:0] div16(input logic signed [21:0] x);
    logic signed [21:0] t;
    t = x + (x[21] ? 22'sd15 : 22'sd0);
    return ERR_W'(t >>> 4);
  endfunction

  function automatic logic signed [Q_W-1:0] div1024(input logic signed [ERR_W-1:0] e);
    logic signed [ERR_W-1:0] t;
    t = e + (e[ERR_W-1] ? ERR_W'(1023) : ERR_W'(0));
    return Q_W'(t >>> 10);
  endfunction

  function automatic logic [7:0] clamp(input logic [7:0] p, input logic signed [Q_W-1:0] q);
    logic signed [Q_W+1:0] v;
    v = $signed({{(Q_W-6){1'b0}}, p}) + (Q_W+2)'(q);
    if (v < 0) return 8'd0;
    else if (v > (Q_W+2)'(255)) return 8'd255;
    else return v[7:0];
  endfunction

  assign px[0] = q_item.red;
  assign px[1] = q_item.green;
  assign px[2] = q_item.blue;

  // effective width and count, position saturated to the row
  always_comb begin
    if (cfg.width == '0) w_eff = WID_W'(1);
    else if (32'(cfg.width) > MAX_WIDTH) w_eff = WID_W'(MAX_WIDTH);
    else w_eff = WID_W'(cfg.width);
    w_last = COL_W'(w_eff - 1'b1);
    col_s  = (col > w_last) ? w_last : col;
    if (cfg.count == '0) n_eff = 9'd1;
    else if (32'(cfg.count) > PALETTE_ENTRIES) n_eff = 9'(PALETTE_ENTRIES);
    else n_eff = cfg.count;
    s0 = SLOT_W'(col_s);
    s1 = s0 + 1'b1;
    s2 = s0 + 2'd2;
    row_end = rtl ? (col_s == '0) : (col_s == w_last);
  end

  // k: 0 current row ahead (7/16), 1 behind-below (3/16), 2 below (5/16), 3 ahead-below (1/16)
  always_comb begin
    case (k)
      2'd0:    rmw_slot = rtl ? s0 : s2;
      2'd1:    rmw_slot = rtl ? s2 : s0;
      2'd2:    rmw_slot = s1;
      default: rmw_slot = rtl ? s0 : s2;
    endcase
    rmw_bank = (k == 2'd0) ? row[0] : !row[0];
    rmw_tag  = (k == 2'd0) ? row : row + 1'b1;
    rmw_addr = {rmw_bank, rmw_slot};
    if ((state == S_RMW_RD) || (state == S_RMW_WR)) e_raddr = rmw_addr;
    else e_raddr = {row[0], s1};
  end

  always_comb begin
    rd_ok = (e_rdata[ENTRY_W-1 -: TAG_W] == rmw_tag);
    for (int c = 0; c < 3; c++) begin
      adj_next[c] = clamp(px[c], div1024((e_rdata[ENTRY_W-1 -: TAG_W] == row) ?
                                  e_rdata[(2-c)*ERR_W +: ERR_W] : '0));
    end
    e_we    = 1'b0;
    e_waddr = rmw_addr;
    e_wdata = {rmw_tag, {(3*ERR_W){1'b0}}};
    if (state == S_CLR) begin
      e_we    = 1'b1;
      e_waddr = clr_addr;
      e_wdata = '0;
    end else if (state == S_RMW_WR) begin
      e_we = 1'b1;
      for (int c = 0; c < 3; c++) begin
        e_wdata[c*ERR_W +: ERR_W] = (rd_ok ? e_rdata[c*ERR_W +: ERR_W] : '0)
                                  + addend[k][c*ERR_W +: ERR_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[e_waddr] <= e_wdata;
    e_rdata <= emem[e_raddr];
  end

  assign out_free = !obuf_v || res_ready;
  assign hold     = (state == S_CLR);

  always_comb begin
    q_pop = 1'b0;
    if ((state == S_IDLE) && q_valid && (q_item.func != FUNC_PIXEL)) q_pop = 1'b1;
    if ((state == S_OUT) && out_free) q_pop = 1'b1;
    pal_wr.en    = (state == S_IDLE) && q_valid && (q_item.func == FUNC_LOAD);
    pal_wr.index = q_item.entry_index;
    pal_wr.rgb   = {q_item.red, q_item.green, q_item.blue};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      row      <= '0;
      col      <= '0;
      rtl      <= 1'b0;
      k        <= '0;
      start    <= 1'b0;
      obuf_v   <= 1'b0;
    end else begin
      if (obuf_v && res_ready) obuf_v <= 1'b0;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == EADDR_W'(EDEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            case (q_item.func)
              FUNC_BEGIN: begin
                row <= row + 2'd2;
                col <= '0;
                rtl <= 1'b0;
              end
              FUNC_PIXEL: begin
                if (cfg.dither) begin
                  state <= S_ADJ;
                end else begin
                  for (int c = 0; c < 3; c++) adj[c] <= px[c];
                  start <= 1'b1;
                  state <= S_WAIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_ADJ: begin
          for (int c = 0; c < 3; c++) adj[c] <= adj_next[c];
          start <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          start <= 1'b0;
          if (srch_rsp.done) begin
            chosen_idx <= srch_rsp.index;
            chosen[0]  <= srch_rsp.rgb[23:16];
            chosen[1]  <= srch_rsp.rgb[15:8];
            chosen[2]  <= srch_rsp.rgb[7:0];
            state      <= cfg.dither ? S_ERR : S_OUT;
          end
        end
        S_ERR: begin
          for (int c = 0; c < 3; c++) begin
            logic signed [8:0]  d;
            logic signed [21:0] x;
            d = $signed({1'b0, adj[c]}) - $signed({1'b0, chosen[c]});
            x = 22'($signed({d, 10'b0}));
            addend[0][(2-c)*ERR_W +: ERR_W] <= div16((x <<< 3) - x);
            addend[1][(2-c)*ERR_W +: ERR_W] <= div16((x <<< 1) + x);
            addend[2][(2-c)*ERR_W +: ERR_W] <= div16((x <<< 2) + x);
            addend[3][(2-c)*ERR_W +: ERR_W] <= div16(x);
          end
          k     <= '0;
          state <= S_RMW_RD;
        end
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: begin
          k     <= k + 1'b1;
          state <= (k == 2'd3) ? S_OUT : S_RMW_RD;
        end
        S_OUT: begin
          if (out_free) begin
            obuf_v            <= 1'b1;
            obuf.palette_index <= chosen_idx;
            obuf.red_out      <= chosen[0];
            obuf.green_out    <= chosen[1];
            obuf.blue_out     <= chosen[2];
            obuf.end_of_row   <= row_end;
            if (row_end) begin
              row <= row + 1'b1;
              rtl <= !rtl;
              col <= rtl ? '0 : w_last;
            end else begin
              col <= rtl ? col_s - 1'b1 : col_s + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    srch_req.start = start;
    srch_req.red   = adj[0];
    srch_req.green = adj[1];
    srch_req.blue  = adj[2];
    srch_req.count = n_eff;
  end

  assign res_valid = obuf_v;
  assign res       = obuf;

endmodule
`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
module tb import pmed_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ERR_ONE    = 1024;
  localparam int SLOTS      = DEF_MAX_WIDTH + 2;
  localparam int HOLD_LEN   = 400;     // long receiver stall, in cycles
  localparam int DRAIN_WAIT = 64;      // tail of loads / begin-frames after last beat
  localparam int CYCLE_CAP  = 600000;  // sweep + ~750 items at worst-case pace, padded

  logic clk;
  logic rst;

  pmed_pix_if pix_bus ();
  pmed_res_if res_bus ();
  pmed_cfg_if cfg_bus ();

  palette_map_error_diffusion u_dut (
    .clk (clk),
    .rst (rst),
    .pix (pix_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Shadow copy of the block: palette, serpentine error rows, config
  // ---------------------------------------------------------------
  logic [23:0] pal_rgb [DEF_PALETTE_ENTRIES];
  int          row_err  [SLOTS][3];   // errors for the row being visited
  int          below_err[SLOTS][3];   // errors piling up for the row after it
  int          col_pos;
  bit          rev_dir;               // 1 while the row runs right to left
  bit          dith_on;
  logic [11:0] width_reg;
  logic [8:0]  count_reg;

  res_t        pending_pix[$];        // nearest-entry beats still owed by the block
  int          err_cnt;
  bit          calm;                  // both sides stop idling while set
  bit          hold_req;

  function automatic void clear_rows();
    for (int s = 0; s < SLOTS; s++)
      for (int c = 0; c < 3; c++) begin
        row_err[s][c]   = 0;
        below_err[s][c] = 0;
      end
  endfunction

  // Nearest palette entry for one pixel, with the diffusion bookkeeping.
  function automatic res_t map_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int   w, col, n, best, min_d, d, diff, err, e7, e3, e5, e1;
    int   adj[3];
    int   ent[3];
    bit   eor;
    res_t o;
    w   = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
    n   = (count_reg == 0) ? 1 : (count_reg > DEF_PALETTE_ENTRIES) ? DEF_PALETTE_ENTRIES
                                                                  : count_reg;
    col = (col_pos > w - 1) ? w - 1 : col_pos;  // width shrunk mid-row
    adj[0] = r;
    adj[1] = g;
    adj[2] = b;
    if (dith_on)
      for (int c = 0; c < 3; c++) begin
        adj[c] += row_err[col + 1][c] / ERR_ONE;
        if (adj[c] < 0) adj[c] = 0;
        else if (adj[c] > 255) adj[c] = 255;
      end
    best  = 0;
    min_d = 2000000000;
    for (int i = 0; i < n; i++) begin
      d = 0;
      for (int c = 0; c < 3; c++) begin
        diff = adj[c] - int'(pal_rgb[i][23 - 8*c -: 8]);
        d += diff * diff;
      end
      if (d < min_d) begin   // strict: first minimum wins a tie
        min_d = d;
        best  = i;
      end
    end
    for (int c = 0; c < 3; c++) ent[c] = pal_rgb[best][23 - 8*c -: 8];
    if (dith_on)
      for (int c = 0; c < 3; c++) begin
        err = (adj[c] - ent[c]) * ERR_ONE;
        e7 = (err * 7) / 16;
        e3 = (err * 3) / 16;
        e5 = (err * 5) / 16;
        e1 = err / 16;
        if (!rev_dir) begin
          row_err[col + 2][c]   += e7;
          below_err[col][c]     += e3;
          below_err[col + 1][c] += e5;
          below_err[col + 2][c] += e1;
        end else begin
          row_err[col][c]       += e7;
          below_err[col + 2][c] += e3;
          below_err[col + 1][c] += e5;
          below_err[col][c]     += e1;
        end
      end
    eor = rev_dir ? (col == 0) : (col >= w - 1);
    if (eor) begin
      // row turn happens with dithering off too
      for (int s = 0; s < SLOTS; s++)
        for (int c = 0; c < 3; c++) begin
          row_err[s][c]   = below_err[s][c];
          below_err[s][c] = 0;
        end
      rev_dir = !rev_dir;
      col_pos = rev_dir ? w - 1 : 0;
    end else begin
      col_pos = rev_dir ? col - 1 : col + 1;
    end
    o.palette_index = best[7:0];
    o.red_out       = ent[0][7:0];
    o.green_out     = ent[1][7:0];
    o.blue_out      = ent[2][7:0];
    o.end_of_row    = eor;
    return o;
  endfunction

  // Applies an accepted beat to the shadow state; pixels return their result.
  function automatic bit apply_item(item_t it, output res_t o);
    o = '0;
    case (it.func)
      FUNC_BEGIN: begin
        clear_rows();
        col_pos = 0;
        rev_dir = 1'b0;
      end
      FUNC_LOAD:  pal_rgb[it.entry_index] = {it.red, it.green, it.blue};
      FUNC_PIXEL: begin
        o = map_pixel(it.red, it.green, it.blue);
        return 1'b1;
      end
      default: ;  // func 3 leaves everything alone
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------
  // Offers one beat; valid stays up after the accepting edge, and the next call
  // either drives the following beat or drops valid for an idle cycle.
  task automatic push_beat(item_t it, bit use_want = 1'b0, res_t want = '0);
    res_t got;
    if (!calm && $urandom_range(99) < 13) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.func        <= it.func;
    pix_bus.entry_index <= it.entry_index;
    pix_bus.red         <= it.red;
    pix_bus.green       <= it.green;
    pix_bus.blue        <= it.blue;
    do @(posedge clk); while (!pix_bus.ready);
    if (apply_item(it, got)) pending_pix.push_back(use_want ? want : got);
  endtask

  // Register writes only with the block idle.
  task automatic write_reg(reg_idx_t idx, logic [11:0] val);
    pix_bus.valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_DITHER: dith_on   = val[0];
      REG_WIDTH:  width_reg = val;
      REG_COUNT:  count_reg = val[8:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] rand_chan();
    // lean on the rails so clamping and exact hits show up often
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic item_t rand_item(int pct_pixel);
    item_t it;
    int    roll;
    roll = $urandom_range(99);
    it.entry_index = 8'($urandom_range(255));
    it.red   = rand_chan();
    it.green = rand_chan();
    it.blue  = rand_chan();
    if (roll < pct_pixel)           it.func = FUNC_PIXEL;
    else if (roll < pct_pixel + 6)  it.func = FUNC_LOAD;
    else if (roll < pct_pixel + 9)  it.func = FUNC_NOP;
    else                            it.func = FUNC_BEGIN;
    return it;
  endfunction

  // ---------------------------------------------------------------
  // Output side: random ready, one long hold-off, in-order compare
  // ---------------------------------------------------------------
  int hold_left;
  bit hold_taken;
  int cyc;

  always @(posedge clk) begin
    res_t want;
    cyc <= cyc + 1;
    if (cyc > CYCLE_CAP) begin
      $display("tb: errors");
      $finish;
    end
    if (rst) begin
      res_bus.ready <= 1'b0;
      hold_left     <= 0;
      hold_taken    <= 1'b0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_left     <= HOLD_LEN;
        hold_taken    <= 1'b1;
        res_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        res_bus.ready <= (hold_left == 1);
      end else begin
        res_bus.ready <= calm || ($urandom_range(99) >= 13);
      end

      if (res_bus.valid && res_bus.ready) begin
        if (pending_pix.size() == 0) begin
          $display("%0t: unexpected beat idx %0d", $realtime, res_bus.palette_index);
          err_cnt++;
        end else begin
          want = pending_pix.pop_front();
          if (res_bus.palette_index !== want.palette_index) begin
            $display("%0t: palette_index exp %0d got %0d", $realtime,
                     want.palette_index, res_bus.palette_index);
            err_cnt++;
          end
          if (res_bus.red_out !== want.red_out) begin
            $display("%0t: red_out exp %0d got %0d", $realtime, want.red_out,
                     res_bus.red_out);
            err_cnt++;
          end
          if (res_bus.green_out !== want.green_out) begin
            $display("%0t: green_out exp %0d got %0d", $realtime, want.green_out,
                     res_bus.green_out);
            err_cnt++;
          end
          if (res_bus.blue_out !== want.blue_out) begin
            $display("%0t: blue_out exp %0d got %0d", $realtime, want.blue_out,
                     res_bus.blue_out);
            err_cnt++;
          end
          if (res_bus.end_of_row !== want.end_of_row) begin
            $display("%0t: end_of_row exp %0b got %0b", $realtime, want.end_of_row,
                     res_bus.end_of_row);
            err_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Directed table: 4-entry palette (black, white, red, blue), width 4,
  // no dithering. Obvious rows carry their answer; the rest use the model.
  // ---------------------------------------------------------------
  typedef struct {
    func_t      f;
    logic [7:0] e, r, g, b;
    bit         typed;
    res_t       want;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{FUNC_BEGIN, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, '{8'd0, 8'd0,   8'd0, 8'd0,   1'b0}},
    '{FUNC_PIXEL, 8'd0,   8'd255, 8'd255, 8'd255, 1'b1,
      '{8'd1, 8'd255, 8'd255, 8'd255, 1'b0}},
    '{FUNC_PIXEL, 8'd0,   8'd250, 8'd5,   8'd5,   1'b1, '{8'd2, 8'd255, 8'd0, 8'd0,   1'b0}},
    // last column: row flips to right to left
    '{FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   8'd255, 1'b1, '{8'd3, 8'd0,   8'd0, 8'd255, 1'b1}},
    '{FUNC_NOP,   8'd7,   8'd1,   8'd2,   8'd3,   1'b0, '0},
    // equidistant from white, red and blue: lowest index wins
    '{FUNC_PIXEL, 8'd0,   8'd255, 8'd0,   8'd255, 1'b0, '0},
    '{FUNC_PIXEL, 8'd0,   8'd128, 8'd128, 8'd128, 1'b0, '0},
    // top entry, outside the searched count
    '{FUNC_LOAD,  8'd255, 8'd9,   8'd9,   8'd9,   1'b0, '0},
    '{FUNC_PIXEL, 8'd0,   8'd1,   8'd2,   8'd3,   1'b0, '0},
    '{FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, '{8'd0, 8'd0,   8'd0, 8'd0,   1'b1}},
    // begin-frame mid-row restarts the row at the first column, left to right
    '{FUNC_PIXEL, 8'd0,   8'd200, 8'd30,  8'd30,  1'b0, '0},
    '{FUNC_BEGIN, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{FUNC_PIXEL, 8'd0,   8'd255, 8'd255, 8'd255, 1'b1,
      '{8'd1, 8'd255, 8'd255, 8'd255, 1'b0}},
    '{FUNC_PIXEL, 8'd0,   8'd255, 8'd0,   8'd255, 1'b0, '0}
  };

  // random phases: dither, width, count; extremes and out-of-range values mixed in
  bit          ph_dith [] = '{1, 1,    0,   1,  1,  0,    1,  1,   0,    1};
  logic [11:0] ph_width[] = '{1, 2048, 640, 7,  5,  0,    13, 3,   4095, 9};
  logic [11:0] ph_count[] = '{1, 256,  256, 16, 37, 0,    2,  511, 100,  256};
  bit          ph_begin[] = '{1, 1,    1,   1,  0,  1,    1,  0,   1,    1};
  int          ph_items[] = '{40, 30,  50,  60, 50, 40,   50, 50,  40,   60};

  initial begin
    item_t it;
    rst                 <= 1'b1;
    pix_bus.valid       <= 1'b0;
    pix_bus.func        <= FUNC_NOP;
    pix_bus.entry_index <= '0;
    pix_bus.red         <= '0;
    pix_bus.green       <= '0;
    pix_bus.blue        <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= REG_NONE;
    cfg_bus.data        <= '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    dith_on   = 1'b0;
    width_reg = 12'd640;
    count_reg = 9'd256;
    col_pos   = 0;
    rev_dir   = 1'b0;
    clear_rows();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Fill every entry so no search ever reads an unwritten one.
    for (int i = 0; i < DEF_PALETTE_ENTRIES; i++) begin
      it.func        = FUNC_LOAD;
      it.entry_index = i[7:0];
      case (i)
        0:       {it.red, it.green, it.blue} = 24'h000000;
        1:       {it.red, it.green, it.blue} = 24'hffffff;
        2:       {it.red, it.green, it.blue} = 24'hff0000;
        3:       {it.red, it.green, it.blue} = 24'h0000ff;
        default: {it.red, it.green, it.blue} = {rand_chan(), rand_chan(), rand_chan()};
      endcase
      push_beat(it);
    end

    write_reg(REG_DITHER, 12'd0);
    write_reg(REG_WIDTH, 12'd4);
    write_reg(REG_COUNT, 12'd4);
    foreach (dir_rows[k]) begin
      it.func        = dir_rows[k].f;
      it.entry_index = dir_rows[k].e;
      it.red         = dir_rows[k].r;
      it.green       = dir_rows[k].g;
      it.blue        = dir_rows[k].b;
      push_beat(it, dir_rows[k].typed, dir_rows[k].want);
    end

    foreach (ph_dith[p]) begin
      write_reg(REG_DITHER, {11'd0, ph_dith[p]});
      write_reg(REG_WIDTH, ph_width[p]);
      write_reg(REG_COUNT, ph_count[p]);
      calm <= (p == 6);   // one phase with no idling on either side
      if (ph_begin[p]) begin
        it = rand_item(0);
        it.func = FUNC_BEGIN;
        push_beat(it);
      end
      for (int k = 0; k < ph_items[p]; k++) begin
        if (p == 3 && k == 10) hold_req <= 1'b1;  // block backs up behind the stall
        push_beat(rand_item(88));
      end
    end

    pix_bus.valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
